// ===== design/pcifd_pkg.sv =====
// Shared types, field-kind codes and opcode prefix-table functions for the field decoder.
package pcifd_pkg;

  // Opcode prefix table geometry
  localparam int OPCODE_BITS = 8;
  localparam int INSTR_COUNT = 39;
  localparam int CODE_W      = 8;                    // full table index width
  localparam int OP_PAD      = CODE_W - OPCODE_BITS; // zero bits padded on the right
  localparam int TABLE_IDS   = 39;                   // ids the default table defines
  localparam int ID_W        = 6;

  // Stream window
  localparam int HEAD_W  = 3;
  localparam int TAIL_W  = 64;
  localparam int WIN_W   = HEAD_W + TAIL_W;
  localparam int VALUE_W = 64;
  localparam int CNT_W   = 7;

  typedef enum logic [3:0] {
    OP_OPCODE  = 4'd0,
    OP_REG     = 4'd1,
    OP_DIR     = 4'd2,
    OP_COND    = 4'd3,
    OP_ADDR    = 4'd4,
    OP_UCONST  = 4'd5,
    OP_SCONST  = 4'd6,
    OP_SHIFT   = 4'd7,
    OP_SIZE    = 4'd8,
    OP_POINTER = 4'd9,
    OP_PFORMAT = 4'd10
  } field_op_t;

  typedef struct packed {
    logic [3:0]        operation;
    logic [HEAD_W-1:0] head_bits;
    logic [TAIL_W-1:0] tail_bits;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [CNT_W-1:0]   consumed_bits;
    logic [CNT_W-1:0]   operand_size;
  } res_item_t;

  // Default prefix table: 8-bit code -> instruction id
  function automatic logic [ID_W-1:0] table_id(input logic [CODE_W-1:0] c);
    logic [CODE_W-1:0] t;
    t = '0;
    if (c < 8'd144) begin
      t = c >> 4;
    end else if (c < 8'd160) begin
      t = 8'd9 + ((c - 8'd144) >> 3);
    end else if (c < 8'd192) begin
      t = 8'd11 + ((c - 8'd160) >> 4);
    end else if (c < 8'd224) begin
      t = 8'd13 + ((c - 8'd192) >> 2);
    end else if (c < 8'd252) begin
      t = 8'd21 + ((c - 8'd224) >> 1);
    end else begin
      t = 8'd35 + (c - 8'd252);
    end
    return t[ID_W-1:0];
  endfunction

  // Code length of each instruction id in the default table
  function automatic logic [CNT_W-1:0] code_len(input logic [ID_W-1:0] id);
    logic [CNT_W-1:0] l;
    l = 7'd8;
    if (id <= 6'd8) begin
      l = 7'd4;
    end else if (id <= 6'd10) begin
      l = 7'd5;
    end else if (id <= 6'd12) begin
      l = 7'd4;
    end else if (id <= 6'd20) begin
      l = 7'd6;
    end else if (id <= 6'd34) begin
      l = 7'd7;
    end
    return l;
  endfunction

endpackage

// ===== design/pcifd_in_stage.sv =====
// Input register stage: captures one beat and holds it until the decode side takes it.
module pcifd_in_stage
  import pcifd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     s_valid,
  output logic     s_ready,
  input  in_item_t s_item,
  output logic     m_valid,
  input  logic     m_ready,
  output in_item_t m_item
);

  logic     valid_r, valid_nxt;
  in_item_t item_r;

  assign s_ready   = !valid_r || m_ready;
  assign valid_nxt = s_ready ? s_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s_ready && s_valid) begin
      item_r <= s_item;
    end
  end

  assign m_valid = valid_r;
  assign m_item  = item_r;

endmodule

// ===== design/pcifd_decode.sv =====
// Combinational field decode of one registered stream window.
module pcifd_decode
  import pcifd_pkg::*;
(
  input  in_item_t  item,
  output res_item_t res
);

  logic [WIN_W-1:0]  win;      // stream bit k sits at win[WIN_W-1-k]
  logic [2:0]        h;
  logic [CODE_W-1:0] code;
  logic [ID_W-1:0]   id;
  logic [6:0]        shf;

  assign win  = {item.head_bits, item.tail_bits};
  assign h    = item.head_bits;
  assign code = CODE_W'(win[WIN_W-1 -: OPCODE_BITS]) << OP_PAD;
  assign id   = table_id(code);
  assign shf  = win[WIN_W-1 -: 7];

  always_comb begin
    res = '0;
    unique case (item.operation)
      OP_OPCODE: begin
        res.value = VALUE_W'(id);
        if ((int'(id) < INSTR_COUNT) && (int'(id) < TABLE_IDS)) begin
          res.consumed_bits = code_len(id);
        end else begin
          res.consumed_bits = CNT_W'(OPCODE_BITS);
        end
      end
      OP_REG, OP_COND: begin
        res.value         = VALUE_W'(h);
        res.consumed_bits = 7'd3;
      end
      OP_DIR: begin
        res.value         = VALUE_W'(h[2]);
        res.consumed_bits = 7'd1;
      end
      OP_POINTER: begin
        res.value         = VALUE_W'(h[2:1]);
        res.consumed_bits = 7'd2;
      end
      OP_PFORMAT: begin
        res.value         = VALUE_W'(win[WIN_W-1 -: 4]);
        res.consumed_bits = 7'd4;
      end
      OP_ADDR, OP_UCONST, OP_SCONST: begin
        // header 0xx / 10x / 110 / 111 picks payload width
        if (!h[2]) begin
          if (item.operation == OP_ADDR) begin
            res.operand_size = 7'd8;
            res.value = {{56{win[65]}}, win[65:58]};
          end else begin
            res.operand_size = 7'd1;
            res.value = (item.operation == OP_SCONST) ? {64{win[65]}} : VALUE_W'(win[65]);
          end
          res.consumed_bits = res.operand_size + 7'd1;
        end else if (!h[1]) begin
          if (item.operation == OP_ADDR) begin
            res.operand_size = 7'd16;
            res.value = {{48{win[64]}}, win[64:49]};
          end else begin
            res.operand_size = 7'd8;
            res.value = (item.operation == OP_SCONST) ? {{56{win[64]}}, win[64:57]}
                                                      : VALUE_W'(win[64:57]);
          end
          res.consumed_bits = res.operand_size + 7'd2;
        end else if (!h[0]) begin
          res.operand_size  = 7'd32;
          res.value = (item.operation == OP_UCONST) ? VALUE_W'(win[63:32])
                                                    : {{32{win[63]}}, win[63:32]};
          res.consumed_bits = 7'd35;
        end else begin
          res.operand_size  = 7'd64;
          res.value         = win[63:0];
          res.consumed_bits = 7'd67;
        end
      end
      OP_SHIFT: begin
        // leading one is the short code for a shift of one
        if (shf[6]) begin
          res.value         = 64'd1;
          res.consumed_bits = 7'd1;
        end else begin
          res.value         = VALUE_W'(shf);
          res.consumed_bits = 7'd7;
        end
      end
      OP_SIZE: begin
        if (!h[2]) begin
          res.value         = h[1] ? 64'd4 : 64'd1;
          res.consumed_bits = 7'd2;
        end else begin
          res.value         = 64'd8 << h[1:0];
          res.consumed_bits = 7'd3;
        end
      end
      default: begin
        res = '0;
      end
    endcase
  end

endmodule

// ===== design/pcifd_out_stage.sv =====
// Result register stage: holds a decoded result until the downstream side takes it.
module pcifd_out_stage
  import pcifd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      s_valid,
  output logic      s_ready,
  input  res_item_t s_item,
  output logic      m_valid,
  input  logic      m_ready,
  output res_item_t m_item
);

  logic      valid_r, valid_nxt;
  res_item_t item_r;

  assign s_ready   = !valid_r || m_ready;
  assign valid_nxt = s_ready ? s_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s_ready && s_valid) begin
      item_r <= s_item;
    end
  end

  assign m_valid = valid_r;
  assign m_item  = item_r;

endmodule

// ===== design/prefix_coded_instruction_field_decoder.sv =====
// Top level of the prefix-coded instruction field decoder.
//
// Decodes one field of a bit-addressed instruction stream per beat. The input
// beat carries the field kind in in_tuser and a 67-bit window in in_tdata
// whose earliest stream bit is head_bits[2]. The result beat gives the decoded
// value (instruction id for opcodes, sign-extended payload for address and
// signed constants), the number of stream bits the field occupies, and the
// payload width for address and constant kinds. Opcodes use the fixed default
// prefix table. Unknown kinds (11..15) return all zeros, i.e. no advance.
// Timing: one beat per cycle sustained while out_tready is held high; an
// accepted beat passes through the input register and then the result
// register before out_tvalid rises, with a single table lookup and mux
// layer between them. in_tready stays high while a result waits, as long as
// the input register is free.
module prefix_coded_instruction_field_decoder
  import pcifd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // [2:0] head_bits, [66:3] tail_bits, [71:67] zero
  input  logic [3:0]  in_tuser,   // [3:0] operation
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata   // [63:0] value, [70:64] consumed_bits,
                                  // [77:71] operand_size, [79:78] zero
);

  in_item_t  in_item, dec_item;
  res_item_t dec_res, out_item;
  logic      dec_valid, dec_ready;

  assign in_item.operation = in_tuser;
  assign in_item.head_bits = in_tdata[2:0];
  assign in_item.tail_bits = in_tdata[66:3];

  pcifd_in_stage u_in (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (in_tvalid),
    .s_ready (in_tready),
    .s_item  (in_item),
    .m_valid (dec_valid),
    .m_ready (dec_ready),
    .m_item  (dec_item)
  );

  pcifd_decode u_dec (
    .item (dec_item),
    .res  (dec_res)
  );

  pcifd_out_stage u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (dec_valid),
    .s_ready (dec_ready),
    .s_item  (dec_res),
    .m_valid (out_tvalid),
    .m_ready (out_tready),
    .m_item  (out_item)
  );

  assign out_tdata = {2'b00, out_item.operand_size, out_item.consumed_bits, out_item.value};

endmodule
